// ===== design/uart_menu_command_parser_assert.svh =====
// assertion macros used by the checker file ucp_checker.sv
`ifndef UART_MENU_COMMAND_PARSER_ASSERT_SVH
`define UART_MENU_COMMAND_PARSER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define UCP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define UCP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/ucp_pkg.sv =====
// ----------------------------------------------------------------------------
// ucp_pkg
// types, character codes and menu level codes of the menu command parser
// ----------------------------------------------------------------------------
`default_nettype none

package ucp_pkg;

	localparam int IN_W  = 8;
	localparam int OUT_W = 80;
	localparam int LVL_W = 3;
	localparam int VAL_W = 32;

	localparam logic [LVL_W-1:0] LVL_ROOT = 3'd0;
	localparam logic [LVL_W-1:0] LVL_SIZE = 3'd1;
	localparam logic [LVL_W-1:0] LVL_ADDR = 3'd2;
	localparam logic [LVL_W-1:0] LVL_MODE = 3'd3;
	localparam logic [LVL_W-1:0] LVL_TEST = 3'd4;

	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_S    = 8'h73;
	localparam logic [7:0] CH_A    = 8'h61;
	localparam logic [7:0] CH_M    = 8'h6D;
	localparam logic [7:0] CH_T    = 8'h74;
	localparam logic [7:0] CH_R    = 8'h72;
	localparam logic [7:0] CH_W    = 8'h77;

	typedef struct packed {
		logic [LVL_W-1:0] level;
		logic [VAL_W-1:0] start;
		logic [VAL_W-1:0] size;
		logic             mode;
		logic             done;
	} step_res_t;

	function automatic logic [7:0] lower_case(input logic [7:0] b);
		logic [7:0] r;
		r = b;
		if (b >= 8'h41 && b <= 8'h5A) begin
			r = b + 8'h20;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== design/uart_menu_command_parser.sv =====
// ----------------------------------------------------------------------------
// uart_menu_command_parser
// menu command parser stepping one received serial byte per beat
// ----------------------------------------------------------------------------
// Bytes arrive on the s_ channel, one per beat, and each gives exactly one
// result beat on the m_ channel: the echoed byte, the menu state after the
// byte, the stored start address, size and mode, and a done flag.
// A byte is captured in an input register, stepped through the menu logic
// and written to the output register with the updated menu state; the result
// shows on m_tvalid once the output register holds it.
// Throughput is one byte per cycle unless a low m_tready stalls the output;
// the menu state feeds back within the single step stage, which sets that rate.
// When m_tready is low the output register holds its beat; the input
// register still takes one more byte, and s_tready falls only once both
// registers are full.
// Reset clears the menu to root, the running value, count, start address,
// size and mode to zero, and empties both registers.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_menu_command_parser #(
	parameter int TEXT_BUFFER_LEN = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	input  wire logic [ucp_pkg::IN_W-1:0]    s_tdata,  // rx_byte
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	// echo_byte, menu_state, test_start, test_size, test_mode, input_done, zero fill
	output logic [ucp_pkg::OUT_W-1:0]        m_tdata
);
	import ucp_pkg::*;

	localparam int CW = $clog2(TEXT_BUFFER_LEN);

	logic [IN_W-1:0]  byte_s1;
	logic             valid_s1;
	logic [LVL_W-1:0] level_q;
	logic [VAL_W-1:0] value_q;
	logic [CW-1:0]    count_q;
	logic [VAL_W-1:0] start_q;
	logic [VAL_W-1:0] size_q;
	logic             mode_q;
	logic [OUT_W-1:0] out_q;
	logic             out_valid_q;

	step_res_t        res;
	logic [VAL_W-1:0] value_nxt;
	logic [CW-1:0]    count_nxt;
	logic             advance;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	ucp_step #(
		.TEXT_BUFFER_LEN(TEXT_BUFFER_LEN)
	) u_step (
		.rx_byte  (byte_s1),
		.level    (level_q),
		.value    (value_q),
		.count    (count_q),
		.start    (start_q),
		.size     (size_q),
		.mode     (mode_q),
		.res      (res),
		.value_nxt(value_nxt),
		.count_nxt(count_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			level_q     <= LVL_ROOT;
			value_q     <= '0;
			count_q     <= '0;
			start_q     <= '0;
			size_q      <= '0;
			mode_q      <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
				level_q     <= res.level;
				value_q     <= value_nxt;
				count_q     <= count_nxt;
				start_q     <= res.start;
				size_q      <= res.size;
				mode_q      <= res.mode;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
		if (advance) begin
			out_q <= {3'b000, res.done, res.mode, res.size, res.start, res.level, byte_s1};
		end
	end

endmodule

`default_nettype wire

// ===== design/ucp_step.sv =====
// ----------------------------------------------------------------------------
// ucp_step
// next-state logic of the menu machine for one received byte
// ----------------------------------------------------------------------------
`default_nettype none

module ucp_step #(
	parameter int TEXT_BUFFER_LEN = 16
) (
	input  wire logic [ucp_pkg::IN_W-1:0]               rx_byte,
	input  wire logic [ucp_pkg::LVL_W-1:0]              level,
	input  wire logic [ucp_pkg::VAL_W-1:0]              value,
	input  wire logic [$clog2(TEXT_BUFFER_LEN)-1:0]     count,
	input  wire logic [ucp_pkg::VAL_W-1:0]              start,
	input  wire logic [ucp_pkg::VAL_W-1:0]              size,
	input  wire logic                                   mode,
	output ucp_pkg::step_res_t                          res,
	output logic [ucp_pkg::VAL_W-1:0]                   value_nxt,
	output logic [$clog2(TEXT_BUFFER_LEN)-1:0]          count_nxt
);
	import ucp_pkg::*;

	localparam int CW = $clog2(TEXT_BUFFER_LEN);
	localparam logic [CW-1:0] CNT_WRAP = CW'(TEXT_BUFFER_LEN - 1);

	logic [7:0]       lc;
	logic [VAL_W-1:0] acc;
	logic [CW-1:0]    cnt_inc;
	logic             is_cr;

	assign lc      = lower_case(rx_byte);
	assign is_cr   = (rx_byte == CH_CR);
	// value*10 + byte - '0', modulo 2^32
	assign acc     = (value << 3) + (value << 1) + VAL_W'(rx_byte) - VAL_W'(CH_ZERO);
	assign cnt_inc = count + CW'(1);

	always_comb begin
		res.level = level;
		res.start = start;
		res.size  = size;
		res.mode  = mode;
		res.done  = 1'b0;
		value_nxt = value;
		count_nxt = count;
		unique case (level)
			LVL_ROOT: begin
				res.done = 1'b1;
				if (lc == CH_S) begin
					res.level = LVL_SIZE;
				end else if (lc == CH_A) begin
					res.level = LVL_ADDR;
				end else if (lc == CH_M) begin
					res.level = LVL_MODE;
				end else if (lc == CH_T) begin
					res.level = LVL_TEST;
				end
			end
			LVL_MODE: begin
				res.done = 1'b1;
				if (lc == CH_R) begin
					res.mode  = 1'b0;
					res.level = LVL_ROOT;
				end else if (lc == CH_W) begin
					res.mode  = 1'b1;
					res.level = LVL_ROOT;
				end
			end
			LVL_SIZE, LVL_ADDR: begin
				if (is_cr) begin
					if (level == LVL_SIZE) begin
						res.size = value;
					end else begin
						res.start = value;
					end
					res.level = LVL_ROOT;
					res.done  = 1'b1;
					value_nxt = '0;
					count_nxt = '0;
				end else if (cnt_inc >= CNT_WRAP) begin
					value_nxt = '0;
					count_nxt = '0;
				end else begin
					value_nxt = acc;
					count_nxt = cnt_inc;
				end
			end
			default: begin
				// test state only echoes
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== design/ucp_checker.sv =====
// ----------------------------------------------------------------------------
// ucp_checker
// port-level checks of the menu command parser, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "uart_menu_command_parser_assert.svh"

module ucp_checker (
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     s_tvalid,
	input wire logic                     s_tready,
	input wire logic [ucp_pkg::IN_W-1:0] s_tdata,
	input wire logic                     m_tvalid,
	input wire logic                     m_tready,
	input wire logic [ucp_pkg::OUT_W-1:0] m_tdata
);
	import ucp_pkg::*;

	logic        out_beat;
	logic        in_test;
	logic        plain_beat;
	logic [64:0] out_store;

	assign out_beat   = m_tvalid && m_tready;
	assign in_test    = (m_tdata[10:8] == LVL_TEST);
	assign plain_beat = m_tvalid && !m_tdata[76];
	// start, size and mode of the result beat
	assign out_store  = m_tdata[75:11];

	// stalled result beat holds
	`UCP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result not held")

	// waiting input beat holds
	`UCP_ASSERT_NEXT(a_in_hold, s_tvalid && !s_tready, s_tvalid && $stable(s_tdata), "input not held")

	// test state is never left
	`UCP_ASSERT_NEXT(a_test_sticky, out_beat && in_test, !m_tvalid || in_test, "menu left test state")

	// stored start, size and mode change only on a beat that completes an input
	`UCP_ASSERT_NOW(a_store_hold, $past(out_beat) && plain_beat, out_store == $past(out_store), "store changed")

endmodule

bind uart_menu_command_parser ucp_checker u_checker (.*);

`default_nettype wire
